/* src/swlru_pkg.sv */
// ----------------------------------------------------------------------------
// swlru_pkg: shared types and constants
// Request and response payload types and default sizes of the size weighted
// LRU cache unit.
// ----------------------------------------------------------------------------
`default_nettype none

package swlru_pkg;

   localparam int SIZE_BITS        = 24;
   localparam int KEY_ID_BITS      = 16;
   localparam int EVICT_BITS       = 5;
   localparam int ENTRIES_DEFAULT  = 16;
   localparam int KEY_BITS_DEFAULT = 16;

   localparam logic [SIZE_BITS-1:0] CAPACITY_RESET = 24'd1048576;
   localparam logic [SIZE_BITS-1:0] SIZE_MAX       = {SIZE_BITS{1'b1}};

   typedef struct packed {
      logic [KEY_ID_BITS-1:0] key_id;
      logic [SIZE_BITS-1:0]   object_size;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic                  stored;
      logic [EVICT_BITS-1:0] evicted_count;
      logic [SIZE_BITS-1:0]  remaining;
   } rsp_type;

endpackage

`default_nettype wire

/* src/size_weighted_lru_cache_unit.sv */
// Steps: key scan over all slots; a miss that fits adds a check and, per eviction, a
// rank read, a slot read and an update; the rank list walk then runs down to the hit
// entry on a hit or through the new entry on an insert; last the response register loads.
// Throughput: one item at a time; a new request is taken only once the unit is back in idle.
// Reset: synchronous, clears all entries at once (valid bits in flops),
// capacity returns to 1048576 and the free budget to capacity.
// ----------------------------------------------------------------------------
// size_weighted_lru_cache_unit: size aware LRU cache controller
// Keeps key and size per slot in a slot RAM and the recency order (rank to
// slot) in a rank RAM; evicts the least recent entries until an object fits.
// ----------------------------------------------------------------------------
`default_nettype none

module size_weighted_lru_cache_unit
   import swlru_pkg::*;
#(
   parameter int ENTRIES  = ENTRIES_DEFAULT,
   parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_wr_en,
   input  wire logic [SIZE_BITS-1:0] csr_wr_data
);

   localparam int IW    = $clog2(ENTRIES);
   localparam int CW    = $clog2(ENTRIES + 1);
   localparam int SW    = KEY_BITS + SIZE_BITS;
   localparam int KCOPY = (KEY_BITS < KEY_ID_BITS) ? KEY_BITS : KEY_ID_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_LOOK, S_DECIDE, S_CHK, S_EV_RANK, S_EV_SLOT, S_EV_UPD,
      S_INS, S_WALK, S_DONE
   } state_type;

   // Control and payload registers
   state_type            state_ff, state_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [SIZE_BITS-1:0] cap_ff, cap_in;
   logic [SIZE_BITS-1:0] free_ff, free_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [IW-1:0]        scan_ff, scan_in;
   logic                 hit_ff, hit_in;
   logic [IW-1:0]        hslot_ff, hslot_in;
   logic                 have_free_ff, have_free_in;
   logic [IW-1:0]        fslot_ff, fslot_in;
   logic [IW-1:0]        victim_ff, victim_in;
   logic [IW-1:0]        prev_ff, prev_in;
   logic [IW-1:0]        last_ff, last_in;
   logic                 stored_ff, stored_in;
   logic [EVICT_BITS-1:0] evict_ff, evict_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // RAM ports
   logic          slot_we;
   logic [IW-1:0] slot_waddr, slot_raddr;
   logic [SW-1:0] slot_wdata, slot_rdata;
   logic          rank_we;
   logic [IW-1:0] rank_waddr, rank_raddr, rank_rdata;

   logic [KEY_BITS-1:0]  req_key;
   logic [KEY_BITS-1:0]  rd_key;
   logic [SIZE_BITS-1:0] rd_size;
   logic [SIZE_BITS:0]   sum_size;
   logic [CW-1:0]        cnt_dec;
   logic                 need_evict;

   swlru_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   swlru_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (rank_waddr),
      .wr_data (prev_ff),
      .rd_addr (rank_raddr),
      .rd_data (rank_rdata)
   );

   always_comb begin
      req_key              = '0;
      req_key[KCOPY-1:0]   = req_data.key_id[KCOPY-1:0];
   end

   assign rd_key     = slot_rdata[SW-1:SIZE_BITS];
   assign rd_size    = slot_rdata[SIZE_BITS-1:0];
   assign sum_size   = {1'b0, free_ff} + {1'b0, rd_size};
   assign cnt_dec    = cnt_ff - CW'(1);
   assign need_evict = (size_ff > free_ff) || (cnt_ff == CW'(ENTRIES));

   // Hold off a request while busy or while a capacity write takes the idle cycle.
   assign req_stall  = (state_ff != S_IDLE) || csr_wr_en;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Slot RAM write only at insert; rank RAM write during the walk.
   assign slot_we    = (state_ff == S_INS);
   assign slot_waddr = fslot_ff;
   assign slot_wdata = {key_ff, size_ff};
   assign rank_we    = (state_ff == S_WALK);
   assign rank_waddr = scan_ff;

   always_comb begin
      case (state_ff)
         S_LOOK:    slot_raddr = scan_ff + IW'(1);
         S_EV_SLOT: slot_raddr = rank_rdata;
         default:   slot_raddr = '0;
      endcase
      case (state_ff)
         S_EV_RANK: rank_raddr = cnt_dec[IW-1:0];
         S_WALK:    rank_raddr = scan_ff + IW'(1);
         default:   rank_raddr = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      size_in      = size_ff;
      cap_in       = cap_ff;
      free_in      = free_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      scan_in      = scan_ff;
      hit_in       = hit_ff;
      hslot_in     = hslot_ff;
      have_free_in = have_free_ff;
      fslot_in     = fslot_ff;
      victim_in    = victim_ff;
      prev_in      = prev_ff;
      last_in      = last_ff;
      stored_in    = stored_ff;
      evict_in     = evict_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      // Drop the response once the transfer completes.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            // Capacity write flushes the whole cache.
            if (csr_wr_en) begin
               cap_in   = csr_wr_data;
               free_in  = csr_wr_data;
               valid_in = '0;
               cnt_in   = '0;
            end else if (req_valid) begin
               key_in       = req_key;
               size_in      = req_data.object_size;
               scan_in      = '0;
               hit_in       = 1'b0;
               have_free_in = 1'b0;
               stored_in    = 1'b0;
               evict_in     = '0;
               state_in     = S_LOOK;
            end
         end
         S_LOOK: begin
            // Slot RAM data for address scan_ff is present this cycle.
            if (valid_ff[scan_ff] && rd_key == key_ff) begin
               hit_in   = 1'b1;
               hslot_in = scan_ff;
            end
            if (!valid_ff[scan_ff] && !have_free_ff) begin
               have_free_in = 1'b1;
               fslot_in     = scan_ff;
            end
            if (scan_ff == IW'(ENTRIES - 1)) begin
               state_in = S_DECIDE;
            end else begin
               scan_in = scan_ff + IW'(1);
            end
         end
         S_DECIDE: begin
            if (hit_ff) begin
               stored_in = 1'b1;
               prev_in   = hslot_ff;
               scan_in   = '0;
               state_in  = S_WALK;
            end else if (size_ff > cap_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (!need_evict) begin
               state_in = S_INS;
            end else if (cnt_ff != '0) begin
               state_in = S_EV_RANK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_EV_RANK: begin
            // Least recent entry sits at rank count-1.
            state_in = S_EV_SLOT;
         end
         S_EV_SLOT: begin
            victim_in = rank_rdata;
            state_in  = S_EV_UPD;
         end
         S_EV_UPD: begin
            free_in = sum_size[SIZE_BITS] ? SIZE_MAX : sum_size[SIZE_BITS-1:0];
            valid_in[victim_ff] = 1'b0;
            cnt_in   = cnt_dec;
            evict_in = evict_ff + EVICT_BITS'(1);
            if (!have_free_ff || victim_ff < fslot_ff) begin
               have_free_in = 1'b1;
               fslot_in     = victim_ff;
            end
            state_in = S_CHK;
         end
         S_INS: begin
            valid_in[fslot_ff] = 1'b1;
            free_in   = free_ff - size_ff;
            stored_in = 1'b1;
            last_in   = cnt_ff[IW-1:0];
            cnt_in    = cnt_ff + CW'(1);
            prev_in   = fslot_ff;
            scan_in   = '0;
            state_in  = S_WALK;
         end
         S_WALK: begin
            // Shift the rank list down by one, new most recent at rank 0.
            prev_in = rank_rdata;
            if (hit_ff ? (rank_rdata == hslot_ff) : (scan_ff == last_ff)) begin
               state_in = S_DONE;
            end else begin
               scan_in = scan_ff + IW'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_in.hit           = hit_ff;
               rsp_in.stored        = stored_ff;
               rsp_in.evicted_count = evict_ff;
               rsp_in.remaining     = free_ff;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAPACITY_RESET;
         free_ff      <= CAPACITY_RESET;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         free_ff      <= free_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff       <= key_in;
      size_ff      <= size_in;
      scan_ff      <= scan_in;
      hit_ff       <= hit_in;
      hslot_ff     <= hslot_in;
      have_free_ff <= have_free_in;
      fslot_ff     <= fslot_in;
      victim_ff    <= victim_in;
      prev_ff      <= prev_in;
      last_ff      <= last_in;
      stored_ff    <= stored_in;
      evict_ff     <= evict_in;
      rsp_ff       <= rsp_in;
   end

endmodule

`default_nettype wire

/* src/swlru_ram.sv */
// ----------------------------------------------------------------------------
// swlru_ram: simple dual port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module swlru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* src/swlru_checker.sv */
// ----------------------------------------------------------------------------
// swlru_checker: port level checks
// Watches the cache unit's ports for response consistency and handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module swlru_checker
   import swlru_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // A hit is always stored.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.hit || rsp_data.stored))
      else $error("hit without stored");

   // A hit evicts nothing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> rsp_data.evicted_count == '0)
      else $error("hit with evictions");

   // One item at a time: a transfer in closes the input next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken during lookup");

endmodule

bind size_weighted_lru_cache_unit swlru_checker u_swlru_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
